// ----- rtl/core/sre_pkg.sv -----
// shared types, constants and opcodes of the risc instruction executor
package sre_pkg;

    // machine widths
    localparam int XLEN       = 32;
    localparam int REG_COUNT  = 32;
    localparam int RIDX_W     = $clog2(REG_COUNT);
    localparam int PLEN_W     = 12;
    localparam int OUT_ADDR_W = 11;
    localparam int IMM_W      = 18;
    localparam int SH_W       = 13;
    localparam int OP_W       = 4;
    localparam int JMP_W      = 28;

    // data memory size
    localparam int DATA_WORDS = 2048;
    localparam int DADDR_W    = $clog2(DATA_WORDS);
    localparam logic [XLEN-1:0] DATA_LIMIT = XLEN'(DATA_WORDS);

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
    localparam logic [OP_W-1:0] OP_MOVI  = 4'd3;
    localparam logic [OP_W-1:0] OP_JEQ   = 4'd4;
    localparam logic [OP_W-1:0] OP_AND   = 4'd5;
    localparam logic [OP_W-1:0] OP_XORI  = 4'd6;
    localparam logic [OP_W-1:0] OP_JMP   = 4'd7;
    localparam logic [OP_W-1:0] OP_LSL   = 4'd8;
    localparam logic [OP_W-1:0] OP_LSR   = 4'd9;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd10;
    localparam logic [OP_W-1:0] OP_STORE = 4'd11;

    // register file write port
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

    // data memory request
    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [DADDR_W-1:0] addr;
        logic [XLEN-1:0]    wdata;
    } t_dm_req;

    // one result beat
    typedef struct packed {
        logic [XLEN-1:0]       next_pc;
        logic                  done_res;
        logic                  branch_taken;
        logic                  reg_write;
        logic [RIDX_W-1:0]     dest_index;
        logic [XLEN-1:0]       dest_value;
        logic                  store_done;
        logic [OUT_ADDR_W-1:0] data_address;
        logic [XLEN-1:0]       store_value;
        logic                  address_error;
    } t_result;

endpackage

// ----- rtl/core/sre_if.sv -----
// channel interfaces of the risc instruction executor

// instruction channel
interface sre_in_if;
    logic                      valid;
    logic                      ready;
    logic [sre_pkg::XLEN-1:0]  instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

// result channel
interface sre_out_if;
    logic                            valid;
    logic                            ready;
    logic [sre_pkg::XLEN-1:0]        next_pc;
    logic                            done_res;
    logic                            branch_taken;
    logic                            reg_write;
    logic [sre_pkg::RIDX_W-1:0]      dest_index;
    logic [sre_pkg::XLEN-1:0]        dest_value;
    logic                            store_done;
    logic [sre_pkg::OUT_ADDR_W-1:0]  data_address;
    logic [sre_pkg::XLEN-1:0]        store_value;
    logic                            address_error;

    modport source (output valid, output next_pc, output done_res, output branch_taken,
                    output reg_write, output dest_index, output dest_value,
                    output store_done, output data_address, output store_value,
                    output address_error, input ready);
    modport sink   (input valid, input next_pc, input done_res, input branch_taken,
                    input reg_write, input dest_index, input dest_value,
                    input store_done, input data_address, input store_value,
                    input address_error, output ready);
endinterface

// program length write channel
interface sre_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sre_pkg::PLEN_W-1:0]  program_length;

    modport source (output valid, output program_length, input ready);
    modport sink   (input valid, input program_length, output ready);
endinterface

// ----- rtl/core/sre_regfile.sv -----
// 32 x 32 register file, two registered read ports, one write port, reset to zero
module sre_regfile (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [sre_pkg::RIDX_W-1:0]    i_rd_addr_a,
    input  logic [sre_pkg::RIDX_W-1:0]    i_rd_addr_b,
    output logic [sre_pkg::XLEN-1:0]      o_rd_data_a,
    output logic [sre_pkg::XLEN-1:0]      o_rd_data_b,
    input  sre_pkg::t_rf_wr               i_wr
);

    logic [sre_pkg::XLEN-1:0]      r_mem [sre_pkg::REG_COUNT];
    logic [sre_pkg::REG_COUNT-1:0] r_vld;
    logic [sre_pkg::XLEN-1:0]      r_rd_a;
    logic [sre_pkg::XLEN-1:0]      r_rd_b;

    // storage and registered reads, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_vld[i_rd_addr_a] ? r_mem[i_rd_addr_a] : '0;
            r_rd_b <= r_vld[i_rd_addr_b] ? r_mem[i_rd_addr_b] : '0;
        end
    end

    // written marks, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- rtl/core/sre_dmem.sv -----
// data memory, single port, registered read, cleared by a sweep after reset
module sre_dmem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sre_pkg::t_dm_req           i_req,
    output logic [sre_pkg::XLEN-1:0]   o_rdata,
    output logic                       o_busy
);

    logic [sre_pkg::XLEN-1:0]    r_mem [sre_pkg::DATA_WORDS];
    logic [sre_pkg::XLEN-1:0]    r_rdata;
    logic                        r_clr_busy;
    logic [sre_pkg::DADDR_W-1:0] r_clr_addr;

    // clearing sweep, one word a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == sre_pkg::DADDR_W'(sre_pkg::DATA_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

// ----- rtl/core/sre_out_queue.sv -----
// two-entry result queue in front of the result channel
module sre_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sre_pkg::t_result   i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output sre_pkg::t_result   o_data
);

    sre_pkg::t_result r_q [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];

endmodule

// ----- rtl/core/simple_risc_instruction_executor.sv -----
// top level of the risc instruction executor: decode, execute and write-back
//
// i_instr carries one instruction word per beat, fetched by the user at the
// pc reported in the previous result; o_res returns exactly one result beat
// per instruction (next pc, done, branch, register write, store, error).
// i_cfg writes program_length and is always ready; write it while idle.
// Flow: the accept edge reads the register file, the next cycle executes
// (alu, multiplier, branch, data memory access) and updates the pc, the
// cycle after that writes the register file back and queues the result.
// No instruction is taken while the previous one is in execute; a write
// landing on the accept edge is bypassed.
// A two-entry result queue lets the next instruction enter while a result
// waits; with a stalled receiver at most two results are held, then ready
// drops until a beat leaves.
// Reset: registers and pc go to zero, program_length to zero; the data
// memory is then cleared by a sweep over all 2048 words, during which no
// instruction is taken.
module simple_risc_instruction_executor (
    input  logic i_clk,
    input  logic i_rst_n,
    sre_in_if.sink    i_instr,
    sre_out_if.source o_res,
    sre_cfg_if.sink   i_cfg
);

    // control registers
    logic [sre_pkg::PLEN_W-1:0] r_prog_len;
    logic [sre_pkg::XLEN-1:0]   r_pc;
    logic [1:0]                 r_inflight;
    logic                       r_b_valid;
    logic                       r_c_valid;

    // execute stage payload
    logic [sre_pkg::XLEN-1:0]   r_b_instr;
    logic                       r_byp_a;
    logic                       r_byp_b;
    logic [sre_pkg::XLEN-1:0]   r_byp_val;

    // write-back stage payload
    sre_pkg::t_result           r_c;
    logic                       r_c_load_ok;

    logic                       in_beat;
    logic                       out_beat;
    logic                       dm_busy;
    logic [sre_pkg::OP_W-1:0]   in_op;
    logic [sre_pkg::RIDX_W-1:0] in_addr_a;
    logic [sre_pkg::RIDX_W-1:0] in_addr_b;
    logic [sre_pkg::XLEN-1:0]   rf_rd_a;
    logic [sre_pkg::XLEN-1:0]   rf_rd_b;
    sre_pkg::t_rf_wr            rf_wr;
    sre_pkg::t_dm_req           dm_req;
    logic [sre_pkg::XLEN-1:0]   dm_rdata;
    sre_pkg::t_result           wb_res;
    sre_pkg::t_result           q_data;
    logic                       q_valid;

    // execute stage decode and datapath
    logic [sre_pkg::OP_W-1:0]   ex_op;
    logic [sre_pkg::RIDX_W-1:0] ex_ra;
    logic [sre_pkg::SH_W-1:0]   ex_sh;
    logic [sre_pkg::XLEN-1:0]   ex_imm;
    logic [sre_pkg::XLEN-1:0]   ex_vb;
    logic [sre_pkg::XLEN-1:0]   ex_v2;
    logic [sre_pkg::XLEN-1:0]   ex_addr;
    logic                       ex_in_range;
    logic [sre_pkg::XLEN-1:0]   n_pc;
    logic [sre_pkg::XLEN-1:0]   ex_res;
    logic                       ex_writes;
    logic                       ex_taken;
    logic                       ex_mem_op;
    sre_pkg::t_result           n_c;
    logic                       n_c_load_ok;

    assign in_beat  = i_instr.valid & i_instr.ready;
    assign out_beat = o_res.valid & o_res.ready;

    // take an instruction when memory clearing is done, execute is free and a result slot is left
    assign i_instr.ready = !dm_busy && !r_b_valid && (r_inflight != 2'd2);
    assign i_cfg.ready   = 1'b1;

    // register read addresses from the incoming word
    assign in_op     = i_instr.instruction[31:28];
    assign in_addr_a = i_instr.instruction[22:18];
    assign in_addr_b = (in_op == sre_pkg::OP_JEQ || in_op == sre_pkg::OP_STORE)
                     ? i_instr.instruction[27:23] : i_instr.instruction[17:13];

    sre_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_beat),
        .i_rd_addr_a (in_addr_a),
        .i_rd_addr_b (in_addr_b),
        .o_rd_data_a (rf_rd_a),
        .o_rd_data_b (rf_rd_b),
        .i_wr        (rf_wr)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_prog_len <= i_cfg.program_length;
        end
    end

    // stage valids and items in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_inflight <= '0;
        end else begin
            r_b_valid  <= in_beat;
            r_c_valid  <= r_b_valid;
            r_inflight <= r_inflight + {1'b0, in_beat} - {1'b0, out_beat};
        end
    end

    // accept: latch the word and catch a write-back landing on the same edge
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_b_instr <= i_instr.instruction;
            r_byp_a   <= rf_wr.en && (rf_wr.addr == in_addr_a);
            r_byp_b   <= rf_wr.en && (rf_wr.addr == in_addr_b);
            r_byp_val <= rf_wr.data;
        end
    end

    // operand fields
    assign ex_op  = r_b_instr[31:28];
    assign ex_ra  = r_b_instr[27:23];
    assign ex_sh  = r_b_instr[sre_pkg::SH_W-1:0];
    assign ex_imm = {{(sre_pkg::XLEN - sre_pkg::IMM_W){r_b_instr[sre_pkg::IMM_W-1]}},
                     r_b_instr[sre_pkg::IMM_W-1:0]};
    assign ex_vb  = r_byp_a ? r_byp_val : rf_rd_a;
    assign ex_v2  = r_byp_b ? r_byp_val : rf_rd_b;

    // data address and range check
    assign ex_addr     = ex_vb + ex_imm;
    assign ex_in_range = ex_addr < sre_pkg::DATA_LIMIT;
    assign ex_mem_op   = (ex_op == sre_pkg::OP_LOAD) || (ex_op == sre_pkg::OP_STORE);

    // alu, multiplier, branch and pc
    always_comb begin
        ex_res    = '0;
        ex_writes = 1'b0;
        ex_taken  = 1'b0;
        n_pc      = r_pc + 1'b1;
        unique case (ex_op)
            sre_pkg::OP_ADD: begin
                ex_res    = ex_vb + ex_v2;
                ex_writes = 1'b1;
            end
            sre_pkg::OP_SUB: begin
                ex_res    = ex_vb - ex_v2;
                ex_writes = 1'b1;
            end
            sre_pkg::OP_MUL: begin
                ex_res    = ex_vb * ex_v2;
                ex_writes = 1'b1;
            end
            sre_pkg::OP_MOVI: begin
                ex_res    = ex_imm;
                ex_writes = 1'b1;
            end
            sre_pkg::OP_JEQ: begin
                if (ex_v2 == ex_vb) begin
                    n_pc     = r_pc + 1'b1 + ex_imm;
                    ex_taken = 1'b1;
                end
            end
            sre_pkg::OP_AND: begin
                ex_res    = ex_vb & ex_v2;
                ex_writes = 1'b1;
            end
            sre_pkg::OP_XORI: begin
                ex_res    = ex_vb ^ ex_imm;
                ex_writes = 1'b1;
            end
            sre_pkg::OP_JMP: begin
                n_pc     = {r_pc[sre_pkg::XLEN-1:sre_pkg::JMP_W],
                            r_b_instr[sre_pkg::JMP_W-1:0]};
                ex_taken = 1'b1;
            end
            sre_pkg::OP_LSL: begin
                ex_res    = (|ex_sh[sre_pkg::SH_W-1:5]) ? '0 : (ex_vb << ex_sh[4:0]);
                ex_writes = 1'b1;
            end
            sre_pkg::OP_LSR: begin
                ex_res    = (|ex_sh[sre_pkg::SH_W-1:5]) ? '0 : (ex_vb >> ex_sh[4:0]);
                ex_writes = 1'b1;
            end
            sre_pkg::OP_LOAD: begin
                ex_writes = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // data memory access from the execute stage
    always_comb begin
        dm_req.rd_en = r_b_valid && (ex_op == sre_pkg::OP_LOAD) && ex_in_range;
        dm_req.wr_en = r_b_valid && (ex_op == sre_pkg::OP_STORE) && ex_in_range;
        dm_req.addr  = ex_addr[sre_pkg::DADDR_W-1:0];
        dm_req.wdata = ex_v2;
    end

    sre_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dm_req),
        .o_rdata (dm_rdata),
        .o_busy  (dm_busy)
    );

    // result fields known at the end of execute
    always_comb begin
        n_c               = '0;
        n_c.next_pc       = n_pc;
        n_c.branch_taken  = ex_taken;
        n_c.reg_write     = ex_writes && (ex_ra != '0);
        n_c.dest_index    = n_c.reg_write ? ex_ra : '0;
        n_c.dest_value    = n_c.reg_write ? ex_res : '0;
        n_c.store_done    = (ex_op == sre_pkg::OP_STORE) && ex_in_range;
        n_c.data_address  = ex_mem_op ? ex_addr[sre_pkg::OUT_ADDR_W-1:0] : '0;
        n_c.store_value   = n_c.store_done ? ex_v2 : '0;
        n_c.address_error = ex_mem_op && !ex_in_range;
        n_c_load_ok       = (ex_op == sre_pkg::OP_LOAD) && ex_in_range && n_c.reg_write;
    end

    // pc and write-back stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else if (r_b_valid) begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_c         <= n_c;
            r_c_load_ok <= n_c_load_ok;
        end
    end

    // write-back: load data, done flag, register write
    always_comb begin
        wb_res            = r_c;
        wb_res.dest_value = r_c_load_ok ? dm_rdata : r_c.dest_value;
        wb_res.done_res   = r_c.next_pc >= {{(sre_pkg::XLEN - sre_pkg::PLEN_W){1'b0}},
                                            r_prog_len};
        rf_wr.en          = r_c_valid && r_c.reg_write;
        rf_wr.addr        = r_c.dest_index;
        rf_wr.data        = wb_res.dest_value;
    end

    sre_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_c_valid),
        .i_data  (wb_res),
        .i_pop   (out_beat),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // result channel
    assign o_res.valid         = q_valid;
    assign o_res.next_pc       = q_data.next_pc;
    assign o_res.done_res      = q_data.done_res;
    assign o_res.branch_taken  = q_data.branch_taken;
    assign o_res.reg_write     = q_data.reg_write;
    assign o_res.dest_index    = q_data.dest_index;
    assign o_res.dest_value    = q_data.dest_value;
    assign o_res.store_done    = q_data.store_done;
    assign o_res.data_address  = q_data.data_address;
    assign o_res.store_value   = q_data.store_value;
    assign o_res.address_error = q_data.address_error;

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench of the risc instruction executor: directed and random programs
`timescale 1ns / 1ps

module tb_top;
    import sre_pkg::*;

    // spare opcodes decode as no operation
    localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd12;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;
    localparam int IMM_MAX         = (1 << (IMM_W - 1)) - 1;
    localparam int IMM_MIN         = -(1 << (IMM_W - 1));
    localparam int ITEMS_PER_PHASE = 400;
    localparam int IDLE_PCT        = 18;

    // architectural shadow of the executor and its queue of expected result beats
    class exec_tracker;
        logic [XLEN-1:0]   regs [REG_COUNT];
        logic [XLEN-1:0]   mem  [DATA_WORDS];
        logic [XLEN-1:0]   pc;
        logic [PLEN_W-1:0] prog_len;
        t_result           pending_results [$];
        int                fails;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (mem[i]) mem[i] = '0;
            pc       = '0;
            prog_len = '0;
            fails    = 0;
        endfunction

        function logic [XLEN-1:0] sext_imm(logic [XLEN-1:0] word);
            return {{(XLEN - IMM_W){word[IMM_W-1]}}, word[IMM_W-1:0]};
        endfunction

        // execute one accepted instruction beat and queue its result
        function void issue(logic [XLEN-1:0] word);
            logic [OP_W-1:0]   op;
            logic [RIDX_W-1:0] ra, rb, rc;
            logic [SH_W-1:0]   sh;
            logic [XLEN-1:0]   imm, vb, vc, nxt, val, addr;
            logic              wr, taken, stored, err;
            t_result           r;
            op     = word[31:28];
            ra     = word[27:23];
            rb     = word[22:18];
            rc     = word[17:13];
            sh     = word[SH_W-1:0];
            imm    = sext_imm(word);
            vb     = regs[rb];
            vc     = regs[rc];
            nxt    = pc + 32'd1;
            val    = '0;
            addr   = '0;
            wr     = 1'b0;
            taken  = 1'b0;
            stored = 1'b0;
            err    = 1'b0;
            r      = '0;
            case (op)
                OP_ADD: begin val = vb + vc; wr = 1'b1; end
                OP_SUB: begin val = vb - vc; wr = 1'b1; end
                OP_MUL: begin val = vb * vc; wr = 1'b1; end
                OP_MOVI: begin val = imm; wr = 1'b1; end
                OP_JEQ: begin
                    if (regs[ra] == vb) begin
                        nxt   = pc + 32'd1 + imm;
                        taken = 1'b1;
                    end
                end
                OP_AND: begin val = vb & vc; wr = 1'b1; end
                OP_XORI: begin val = vb ^ imm; wr = 1'b1; end
                OP_JMP: begin
                    nxt   = {pc[XLEN-1:JMP_W], word[JMP_W-1:0]};
                    taken = 1'b1;
                end
                OP_LSL: begin val = (sh >= SH_W'(XLEN)) ? '0 : (vb << sh); wr = 1'b1; end
                OP_LSR: begin val = (sh >= SH_W'(XLEN)) ? '0 : (vb >> sh); wr = 1'b1; end
                OP_LOAD: begin
                    addr = vb + imm;
                    if (addr < DATA_LIMIT) val = mem[addr[DADDR_W-1:0]];
                    else err = 1'b1;
                    wr = 1'b1;
                end
                OP_STORE: begin
                    addr = vb + imm;
                    if (addr < DATA_LIMIT) begin
                        mem[addr[DADDR_W-1:0]] = regs[ra];
                        r.store_value          = regs[ra];
                        stored                 = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                default: ;
            endcase
            // r0 stays zero, its writes are dropped
            if (wr && ra != '0) regs[ra] = val;
            else wr = 1'b0;
            pc = nxt;
            r.next_pc       = nxt;
            r.done_res      = (nxt >= XLEN'(prog_len));
            r.branch_taken  = taken;
            r.reg_write     = wr;
            r.dest_index    = wr ? ra : '0;
            r.dest_value    = wr ? val : '0;
            r.store_done    = stored;
            r.data_address  = addr[OUT_ADDR_W-1:0];
            r.address_error = err;
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
            fails++;
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        endtask

        task compare(string field, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
            if (got !== want) report(field, got, want);
        endtask

        // check one accepted result beat against the oldest expectation
        task retire(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("unexpected result beat, next_pc", got.next_pc, '0);
                return;
            end
            want = pending_results.pop_front();
            compare("next_pc", got.next_pc, want.next_pc);
            compare("done_res", got.done_res, want.done_res);
            compare("branch_taken", got.branch_taken, want.branch_taken);
            compare("reg_write", got.reg_write, want.reg_write);
            compare("dest_index", got.dest_index, want.dest_index);
            compare("dest_value", got.dest_value, want.dest_value);
            compare("store_done", got.store_done, want.store_done);
            compare("data_address", got.data_address, want.data_address);
            compare("store_value", got.store_value, want.store_value);
            compare("address_error", got.address_error, want.address_error);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic no_idle;
    exec_tracker sb;

    sre_in_if  in_ch ();
    sre_out_if res_ch ();
    sre_cfg_if cfg_ch ();

    simple_risc_instruction_executor dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_instr (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // 20 ns clock
    always #10 clk = ~clk;

    // receiver stalls at random outside the steady stretch
    always @(posedge clk) begin
        res_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // result monitor
    always @(posedge clk) begin
        t_result got;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got.next_pc       = res_ch.next_pc;
            got.done_res      = res_ch.done_res;
            got.branch_taken  = res_ch.branch_taken;
            got.reg_write     = res_ch.reg_write;
            got.dest_index    = res_ch.dest_index;
            got.dest_value    = res_ch.dest_value;
            got.store_done    = res_ch.store_done;
            got.data_address  = res_ch.data_address;
            got.store_value   = res_ch.store_value;
            got.address_error = res_ch.address_error;
            sb.retire(got);
        end
    end

    // instruction encoders
    function automatic logic [XLEN-1:0] enc_r(logic [OP_W-1:0] op, logic [RIDX_W-1:0] ra,
                                              logic [RIDX_W-1:0] rb, logic [RIDX_W-1:0] rc);
        return {op, ra, rb, rc, SH_W'($urandom())};
    endfunction

    function automatic logic [XLEN-1:0] enc_i(logic [OP_W-1:0] op, logic [RIDX_W-1:0] ra,
                                              logic [RIDX_W-1:0] rb, logic [IMM_W-1:0] imm);
        return {op, ra, rb, imm};
    endfunction

    function automatic logic [XLEN-1:0] enc_sh(logic [OP_W-1:0] op, logic [RIDX_W-1:0] ra,
                                               logic [RIDX_W-1:0] rb, logic [SH_W-1:0] sh);
        return {op, ra, rb, RIDX_W'($urandom()), sh};
    endfunction

    function automatic logic [XLEN-1:0] enc_j(logic [JMP_W-1:0] target);
        return {OP_JMP, target};
    endfunction

    // random instruction, mostly well formed against the current register contents
    function automatic logic [XLEN-1:0] gen_word();
        logic [OP_W-1:0]   op;
        logic [RIDX_W-1:0] ra, rb, rc;
        logic [XLEN-1:0]   target, gap;
        int                off;
        if ($urandom_range(0, 99) < 8) return $urandom();
        ra = RIDX_W'($urandom());
        rb = RIDX_W'($urandom());
        rc = RIDX_W'($urandom());
        if ($urandom_range(0, 99) < 5) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else op = OP_W'($urandom_range(OP_ADD, OP_STORE));
        case (op)
            OP_MOVI, OP_XORI: return enc_i(op, ra, rb, IMM_W'($urandom()));
            OP_LSL, OP_LSR: begin
                if ($urandom_range(0, 99) < 80)
                    return enc_sh(op, ra, rb, SH_W'($urandom_range(0, 40)));
                return enc_sh(op, ra, rb, SH_W'($urandom()));
            end
            OP_JEQ: begin
                // about half compare a register with itself
                if ($urandom_range(0, 1) == 1) rb = ra;
                off = $urandom_range(0, 40) - 20;
                return enc_i(op, ra, rb, IMM_W'(off));
            end
            OP_JMP: begin
                if ($urandom_range(0, 99) < 95) return enc_j(JMP_W'($urandom_range(0, 4095)));
                return enc_j(JMP_W'($urandom()));
            end
            OP_LOAD, OP_STORE: begin
                if ($urandom_range(0, 99) < 15) return enc_i(op, ra, rb, IMM_W'($urandom()));
                // aim at a small hot region so loads meet earlier stores
                if ($urandom_range(0, 99) < 70) target = $urandom_range(0, 63);
                else target = $urandom_range(0, DATA_WORDS - 1);
                gap = target - sb.regs[rb];
                if ($signed(gap) > IMM_MAX || $signed(gap) < IMM_MIN) begin
                    rb  = '0;
                    gap = target;
                end
                return enc_i(op, ra, rb, gap[IMM_W-1:0]);
            end
            OP_ADD, OP_SUB, OP_MUL, OP_AND: return enc_r(op, ra, rb, rc);
            default: return {op, JMP_W'($urandom())};
        endcase
    endfunction

    // one instruction beat, with random idle cycles ahead of it
    task automatic send_word(input logic [XLEN-1:0] word);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.instruction <= word;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        sb.issue(word);
    endtask

    // wait until every expected result beat has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_length(input logic [PLEN_W-1:0] len);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.program_length <= len;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        sb.prog_len = len;
        cfg_ch.valid <= 1'b0;
    endtask

    // main sequence
    initial begin
        logic [XLEN-1:0]   directed [$];
        logic [PLEN_W-1:0] lengths [5];
        int                count;
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        no_idle               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.instruction     = '0;
        res_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.program_length = '0;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, each opcode, r0 writes, wide shifts,
        // out of range accesses, pc wrap and jump upper bits
        directed.push_back(enc_i(OP_MOVI, 5'd1, 5'd0, 18'h1FFFF));
        directed.push_back(enc_i(OP_MOVI, 5'd2, 5'd0, 18'h20000));
        directed.push_back(enc_i(OP_MOVI, 5'd0, 5'd0, 18'h00005));
        directed.push_back(enc_r(OP_ADD, 5'd3, 5'd1, 5'd2));
        directed.push_back(enc_r(OP_SUB, 5'd4, 5'd2, 5'd1));
        directed.push_back(enc_r(OP_MUL, 5'd5, 5'd1, 5'd2));
        directed.push_back(enc_r(OP_AND, 5'd6, 5'd1, 5'd2));
        directed.push_back(enc_i(OP_XORI, 5'd7, 5'd2, 18'h3FFFF));
        directed.push_back(enc_sh(OP_LSL, 5'd8, 5'd7, 13'd31));
        directed.push_back(enc_sh(OP_LSL, 5'd9, 5'd7, 13'd32));
        directed.push_back(enc_sh(OP_LSR, 5'd10, 5'd7, 13'h1FFF));
        directed.push_back(enc_sh(OP_LSR, 5'd11, 5'd7, 13'd1));
        directed.push_back(enc_i(OP_MOVI, 5'd12, 5'd0, 18'(DATA_WORDS - 1)));
        directed.push_back(enc_i(OP_STORE, 5'd7, 5'd12, 18'd0));
        directed.push_back(enc_i(OP_LOAD, 5'd13, 5'd12, 18'd0));
        directed.push_back(enc_i(OP_STORE, 5'd7, 5'd12, 18'd1));
        directed.push_back(enc_i(OP_LOAD, 5'd14, 5'd12, 18'd1));
        directed.push_back(enc_i(OP_LOAD, 5'd0, 5'd0, 18'h20000));
        directed.push_back(enc_i(OP_JEQ, 5'd1, 5'd2, 18'd5));
        directed.push_back(enc_i(OP_JEQ, 5'd0, 5'd0, 18'h20000));
        directed.push_back(enc_j(28'hFFFFFFF));
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            directed.push_back({OP_W'(op), JMP_W'($urandom())});
        write_length(12'd16);
        foreach (directed[i]) send_word(directed[i]);
        drain();

        // random phases, one program length each
        lengths = '{12'd0, 12'hFFF, 12'd2048, PLEN_W'($urandom()), 12'd1};
        count = 0;
        foreach (lengths[p]) begin
            write_length(lengths[p]);
            repeat (ITEMS_PER_PHASE) begin
                // steady stretch with no idling on either side
                no_idle <= (count >= 700 && count < 1100);
                send_word(gen_word());
                count++;
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (sb.fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/sre_pkg.sv
rtl/core/sre_if.sv
rtl/core/sre_regfile.sv
rtl/core/sre_dmem.sv
rtl/core/sre_out_queue.sv
rtl/core/simple_risc_instruction_executor.sv
sim/tb_top.sv
